@@ hw/rtl/psws_pkg.sv @@
// ----------------------------------------------------------------------------
// psws_pkg
// Shared types and constants for the periodic seed weight scorer.
// ----------------------------------------------------------------------------
package psws_pkg;

  // Field widths
  localparam int PAT_W  = 64;   // pattern bits, one cell each
  localparam int LEN_W  = 7;    // pattern_len
  localparam int IDX_W  = 6;    // cell index
  localparam int RL_W   = 10;   // read_len and weights
  localparam int WH_W   = 9;    // whole = L/n - 1
  localparam int STAT_W = 2;

  localparam logic [LEN_W-1:0] MAX_PATTERN_LEN = 7'd64;
  localparam logic [RL_W-1:0]  MAX_READ_LEN    = 10'd512;
  localparam logic [RL_W-1:0]  READ_LEN_RESET  = 10'd100;

  // Result status codes
  typedef enum logic [STAT_W-1:0] {
    STAT_NA       = 2'd0,
    STAT_BELOW    = 2'd1,
    STAT_EQUAL    = 2'd2,
    STAT_NEW_BEST = 2'd3
  } status_t;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_COUNT,
    S_MUL,
    S_SCAN,
    S_OUT
  } state_t;

  // Control from the sequencer to the cell ring
  typedef struct packed {
    logic             load;
    logic             rotate;
    logic [IDX_W-1:0] last_idx;
  } ring_ctrl_t;

endpackage

@@ hw/rtl/psws_cell.sv @@
// ----------------------------------------------------------------------------
// psws_cell
// One pattern bit of the rotating ring; takes its neighbor's bit each step.
// ----------------------------------------------------------------------------
module psws_cell (
  input  logic clk,
  input  logic load,
  input  logic load_bit,
  input  logic rotate,
  input  logic nbr_bit,
  input  logic wrap_bit,
  input  logic is_last,
  output logic q
);

  // Load a new pattern bit, or shift toward cell 0 with wrap at the last cell
  always_ff @(posedge clk) begin
    if (load) begin
      q <= load_bit;
    end else if (rotate) begin
      q <= is_last ? wrap_bit : nbr_bit;
    end
  end

endmodule

@@ hw/rtl/psws_ring.sv @@
// ----------------------------------------------------------------------------
// psws_ring
// Chain of pattern cells forming a ring of programmable length n. Each
// rotation moves bit j+1 into cell j and cell 0 into cell n-1.
// ----------------------------------------------------------------------------
module psws_ring (
  input  logic                    clk,
  input  psws_pkg::ring_ctrl_t    ctrl,
  input  logic [psws_pkg::PAT_W-1:0] load_bits,
  output logic [psws_pkg::PAT_W-1:0] bits
);

  genvar i;
  generate
    for (i = 0; i < psws_pkg::PAT_W; i++) begin : g_cell
      logic nbr;
      logic last;

      // Top cell has no upper neighbor; it takes the wrap bit when it is the last cell, else a zero
      if (i == psws_pkg::PAT_W - 1) begin : g_top
        assign nbr = 1'b0;
      end else begin : g_mid
        assign nbr = bits[i+1];
      end

      assign last = (ctrl.last_idx == psws_pkg::IDX_W'(i));

      psws_cell u_cell (
        .clk      (clk),
        .load     (ctrl.load),
        .load_bit (load_bits[i]),
        .rotate   (ctrl.rotate),
        .nbr_bit  (nbr),
        .wrap_bit (bits[0]),
        .is_last  (last),
        .q        (bits[i])
      );
    end
  endgenerate

endmodule

@@ hw/rtl/periodic_seed_weight_scorer.sv @@
// ----------------------------------------------------------------------------
// periodic_seed_weight_scorer
// Scores the best periodic seed start of one block pattern for a read length.
// ----------------------------------------------------------------------------
// Steps after the input item is taken: a 10-step serial divide, n ring
//   rotations to count ones (n = length), a multiply step, and n ring
//   rotations that test one start each, then the result goes out.
// Bad length: result goes out with no divide; read too short: after the divide.
// One item at a time: a new item is taken only when idle; a finished item waits
//   in the output register while the next item is taken.
// Reset (rst, synchronous): read_len = 100, running best = 0, output empty.
// ----------------------------------------------------------------------------
module periodic_seed_weight_scorer (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_wen,
  input  logic [9:0]  cfg_wdata,   // read_len
  // input items
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,     // [63:0] pattern, [70:64] pattern_len, pad
  // result items
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata      // [9:0] block_weight, [15:10] best_start,
                                   // [25:16] running_best, [27:26] status, pad
);

  psws_pkg::state_t state, state_next;

  logic [psws_pkg::RL_W-1:0]   read_len;
  logic [psws_pkg::LEN_W-1:0]  n_reg;
  logic [psws_pkg::LEN_W-1:0]  n_in;
  logic [psws_pkg::LEN_W-1:0]  n_last;
  logic [psws_pkg::LEN_W-1:0]  cnt;
  logic                        n_bad;

  // divider
  logic [psws_pkg::RL_W-1:0]   qd, qd_next;
  logic [psws_pkg::LEN_W-1:0]  r, r_next, r_shift;
  logic                        q_ge;

  logic [psws_pkg::WH_W-1:0]   whole;
  logic [psws_pkg::IDX_W-1:0]  rem;
  logic [psws_pkg::IDX_W-1:0]  add_idx;
  logic [psws_pkg::LEN_W-1:0]  ones;
  logic [psws_pkg::IDX_W-1:0]  win;
  logic [psws_pkg::LEN_W-1:0]  win_next;
  logic [psws_pkg::RL_W-1:0]   base;
  logic [psws_pkg::RL_W-1:0]   score;
  logic [psws_pkg::RL_W-1:0]   weight;
  logic [psws_pkg::IDX_W-1:0]  start;
  logic                        found;
  logic [psws_pkg::RL_W-1:0]   best_weight;
  logic [psws_pkg::RL_W-1:0]   best_next;
  psws_pkg::status_t           status;

  psws_pkg::ring_ctrl_t        ring_ctrl;
  logic [psws_pkg::PAT_W-1:0]  ring_bits;
  logic                        b_head, b_end, b_drop, b_add, start_ok;
  logic                        accept, fire;

  logic [psws_pkg::RL_W-1:0]   out_weight;
  logic [psws_pkg::IDX_W-1:0]  out_start;
  logic [psws_pkg::RL_W-1:0]   out_best;
  psws_pkg::status_t           out_status;

  assign n_in   = s_tdata[70:64];
  assign n_bad  = (n_in == '0) || (n_in > psws_pkg::MAX_PATTERN_LEN);
  assign n_last = n_reg - psws_pkg::LEN_W'(1);
  assign accept = s_tvalid && s_tready;
  assign fire   = (state == psws_pkg::S_OUT) && (!m_tvalid || m_tready);

  // One restoring divide step: remainder stays below n, so 6 bits shift up
  assign r_shift = {r[psws_pkg::IDX_W-1:0], qd[psws_pkg::RL_W-1]};
  assign q_ge    = (r_shift >= n_reg);
  assign r_next  = q_ge ? (r_shift - n_reg) : r_shift;
  assign qd_next = {qd[psws_pkg::RL_W-2:0], q_ge};

  // Ring taps: cell j holds bit (p+j) mod n during the scan
  assign b_head   = ring_bits[0];
  assign b_end    = ring_bits[rem];
  assign b_drop   = ring_bits[1];
  assign b_add    = ring_bits[add_idx];
  assign start_ok = b_head && b_end;
  assign score    = base + psws_pkg::RL_W'(win);
  assign win_next = psws_pkg::LEN_W'(win) - psws_pkg::LEN_W'(b_drop)
                  + psws_pkg::LEN_W'(b_add);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      psws_pkg::S_IDLE: begin
        if (s_tvalid) begin
          state_next = n_bad ? psws_pkg::S_OUT : psws_pkg::S_DIV;
        end
      end
      psws_pkg::S_DIV: begin
        if (cnt == psws_pkg::LEN_W'(psws_pkg::RL_W - 1)) begin
          state_next = (qd_next < psws_pkg::RL_W'(2)) ? psws_pkg::S_OUT
                                                      : psws_pkg::S_COUNT;
        end
      end
      psws_pkg::S_COUNT: begin
        if (cnt == n_last) begin
          state_next = psws_pkg::S_MUL;
        end
      end
      psws_pkg::S_MUL: state_next = psws_pkg::S_SCAN;
      psws_pkg::S_SCAN: begin
        if (cnt == n_last) begin
          state_next = psws_pkg::S_OUT;
        end
      end
      psws_pkg::S_OUT: begin
        if (!m_tvalid || m_tready) begin
          state_next = psws_pkg::S_IDLE;
        end
      end
      default: state_next = psws_pkg::S_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    s_tready           = (state == psws_pkg::S_IDLE);
    ring_ctrl.load     = (state == psws_pkg::S_IDLE) && s_tvalid;
    ring_ctrl.rotate   = (state == psws_pkg::S_COUNT) || (state == psws_pkg::S_SCAN);
    ring_ctrl.last_idx = n_last[psws_pkg::IDX_W-1:0];
  end

  // Compare against the running best
  always_comb begin
    best_next = best_weight;
    status    = psws_pkg::STAT_NA;
    if (found) begin
      if (weight > best_weight) begin
        status    = psws_pkg::STAT_NEW_BEST;
        best_next = weight;
      end else if (weight == best_weight) begin
        status = psws_pkg::STAT_EQUAL;
      end else begin
        status = psws_pkg::STAT_BELOW;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= psws_pkg::S_IDLE;
      read_len    <= psws_pkg::READ_LEN_RESET;
      best_weight <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wen) begin
        read_len <= cfg_wdata;
      end
      if (fire) begin
        best_weight <= best_next;
        m_tvalid    <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    // step counter restarts on every state change
    cnt <= (state_next != state) ? '0 : cnt + psws_pkg::LEN_W'(1);

    case (state)
      psws_pkg::S_IDLE: begin
        if (accept) begin
          n_reg <= n_in;
          qd    <= (read_len > psws_pkg::MAX_READ_LEN) ? psws_pkg::MAX_READ_LEN
                                                       : read_len;
          r     <= '0;
          found <= 1'b0;
          ones  <= '0;
          win   <= '0;
        end
      end
      psws_pkg::S_DIV: begin
        qd    <= qd_next;
        r     <= r_next;
        whole <= psws_pkg::WH_W'(qd_next - psws_pkg::RL_W'(1));
        rem   <= r_next[psws_pkg::IDX_W-1:0];
      end
      psws_pkg::S_COUNT: begin
        // count all ones, and ones at positions 1..rem for the first window
        ones <= ones + psws_pkg::LEN_W'(b_head);
        if ((cnt != '0) && (cnt <= psws_pkg::LEN_W'(rem))) begin
          win <= win + psws_pkg::IDX_W'(b_head);
        end
      end
      psws_pkg::S_MUL: begin
        base    <= psws_pkg::RL_W'(whole * ones) + psws_pkg::RL_W'(1);
        add_idx <= (psws_pkg::LEN_W'(rem) + psws_pkg::LEN_W'(1) == n_reg)
                   ? '0 : rem + psws_pkg::IDX_W'(1);
      end
      psws_pkg::S_SCAN: begin
        // keep the first start with the highest score
        if (start_ok && (!found || score > weight)) begin
          weight <= score;
          start  <= cnt[psws_pkg::IDX_W-1:0];
          found  <= 1'b1;
        end
        // slide the window of rem bits by one position
        if (rem != '0) begin
          win <= win_next[psws_pkg::IDX_W-1:0];
        end
      end
      default: ;
    endcase

    // Hold the finished item for the output side
    if (fire) begin
      out_weight <= found ? weight : '0;
      out_start  <= found ? start : '0;
      out_best   <= best_next;
      out_status <= status;
    end
  end

  psws_ring u_ring (
    .clk       (clk),
    .ctrl      (ring_ctrl),
    .load_bits (s_tdata[psws_pkg::PAT_W-1:0]),
    .bits      (ring_bits)
  );

  assign m_tdata = {4'b0, out_status, out_best, out_start, out_weight};

endmodule

@@ hw/rtl/psws_checker.sv @@
// ----------------------------------------------------------------------------
// psws_checker
// Port-level checks on the result stream of the scorer.
// ----------------------------------------------------------------------------
module psws_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata
);

  logic [9:0] weight;
  logic [5:0] start;
  logic [9:0] best;
  logic [1:0] stat;

  assign weight = m_tdata[9:0];
  assign start  = m_tdata[15:10];
  assign best   = m_tdata[25:16];
  assign stat   = m_tdata[27:26];

  // Hold a stalled item
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result item changed while stalled");

  // Drop weight and start when the block does not apply
  a_na_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (stat == psws_pkg::STAT_NA) |-> (weight == 10'd0) && (start == 6'd0))
    else $error("not-applicable item carries a weight or start");

  // A new or equal best must match the running best
  a_best_eq: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && ((stat == psws_pkg::STAT_NEW_BEST) || (stat == psws_pkg::STAT_EQUAL))
    |-> (weight == best))
    else $error("best weight disagrees with running best");

  // A weight below best really is lower, and is not zero
  a_below: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (stat == psws_pkg::STAT_BELOW) |-> (weight < best) && (weight != 10'd0))
    else $error("below-best item not below running best");

endmodule

bind periodic_seed_weight_scorer psws_checker u_psws_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

@@ tb/psws_score_checker.sv @@
// ----------------------------------------------------------------------------
// psws_score_checker
// Watches the config port and both item channels of the periodic seed weight
// scorer, predicts every result item from each accepted input item, and
// compares the results field by field in order of arrival.
// ----------------------------------------------------------------------------
module psws_score_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wen,
  input  logic [9:0]  cfg_wdata,   // read_len
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [71:0] s_tdata,     // [63:0] pattern, [70:64] pattern_len, pad
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [31:0] m_tdata,     // [9:0] block_weight, [15:10] best_start,
                                   // [25:16] running_best, [27:26] status, pad
  output int          fail_count,
  output int          expected_left
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_PRINTS = 40;

  typedef struct packed {
    logic [psws_pkg::RL_W-1:0]  weight;
    logic [psws_pkg::IDX_W-1:0] start;
    logic [psws_pkg::RL_W-1:0]  running;
    psws_pkg::status_t          status;
  } seed_score_t;

  logic [psws_pkg::RL_W-1:0] cur_read_len;
  logic [psws_pkg::RL_W-1:0] peak_weight;
  seed_score_t               scores_due[$];
  seed_score_t               want;

  // Print one mismatch line (up to a cap) and count it
  task automatic report_mismatch(input string what, input int got, input int exp_val);
    if (fail_count < MAX_PRINTS)
      $display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, exp_val);
    fail_count++;
  endtask

  // Score one block at the current read length and advance the running best
  function automatic seed_score_t score_block(input logic [psws_pkg::PAT_W-1:0] pat,
                                              input logic [psws_pkg::LEN_W-1:0] n_in);
    seed_score_t res;
    int  n, len, whole, rem, ones, score, best_score, p, k;
    bit  found;
    n          = int'(n_in);
    len        = int'((cur_read_len > psws_pkg::MAX_READ_LEN) ? psws_pkg::MAX_READ_LEN
                                                              : cur_read_len);
    found      = 1'b0;
    best_score = 0;
    res.weight = '0;
    res.start  = '0;
    res.status = psws_pkg::STAT_NA;
    if (n >= 1 && n <= int'(psws_pkg::MAX_PATTERN_LEN) && len / n >= 2) begin
      whole = len / n - 1;
      rem   = len % n;
      ones  = 0;
      for (p = 0; p < n; p++) ones += int'(pat[p]);
      // try each start whose own bit and end bit are both set
      for (p = 0; p < n; p++) begin
        if (pat[p] && pat[(p + rem) % n]) begin
          score = whole * ones + 1;
          for (k = 1; k <= rem; k++) score += int'(pat[(p + k) % n]);
          if (!found || score > best_score) begin
            best_score = score;
            res.start  = psws_pkg::IDX_W'(p);
            found      = 1'b1;
          end
        end
      end
    end
    if (found) begin
      res.weight = psws_pkg::RL_W'(best_score);
      if (best_score > int'(peak_weight)) begin
        res.status  = psws_pkg::STAT_NEW_BEST;
        peak_weight = psws_pkg::RL_W'(best_score);
      end else if (best_score == int'(peak_weight)) begin
        res.status = psws_pkg::STAT_EQUAL;
      end else begin
        res.status = psws_pkg::STAT_BELOW;
      end
    end
    res.running = peak_weight;
    return res;
  endfunction

  // Track config, check results against the oldest prediction, queue new ones
  always @(posedge clk) begin
    if (rst) begin
      cur_read_len = psws_pkg::READ_LEN_RESET;
      peak_weight  = '0;
      scores_due.delete();
    end else begin
      if (cfg_wen) cur_read_len = cfg_wdata;
      if (m_tvalid && m_tready) begin
        if (scores_due.size() == 0) begin
          report_mismatch("result item with none due", int'(m_tdata), 0);
        end else begin
          want = scores_due.pop_front();
          if (m_tdata[9:0] !== want.weight)
            report_mismatch("block_weight", int'(m_tdata[9:0]), int'(want.weight));
          if (m_tdata[15:10] !== want.start)
            report_mismatch("best_start", int'(m_tdata[15:10]), int'(want.start));
          if (m_tdata[25:16] !== want.running)
            report_mismatch("running_best", int'(m_tdata[25:16]), int'(want.running));
          if (m_tdata[27:26] !== want.status)
            report_mismatch("status", int'(m_tdata[27:26]), int'(want.status));
        end
      end
      if (s_tvalid && s_tready)
        scores_due.push_back(score_block(s_tdata[63:0], s_tdata[70:64]));
    end
    expected_left = scores_due.size();
  end

endmodule

@@ tb/periodic_seed_weight_scorer_test.sv @@
// ----------------------------------------------------------------------------
// periodic_seed_weight_scorer_test
// Drives block patterns through the scorer over a sweep of read lengths, with
// random gaps and back-pressure, and reports the verdict from the checker.
// ----------------------------------------------------------------------------
module periodic_seed_weight_scorer_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_PHASES = 13;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wen = 1'b0;
  logic [9:0]  cfg_wdata = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [71:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;

  int fail_count;
  int expected_left;
  int stall_left = 0;
  bit send_steady = 1'b0;
  bit ready_steady = 1'b0;

  // Read length per phase (-1 picks one at random) and items per phase
  int phase_read_len [NUM_PHASES] = '{7, 40, 0, 1, 2, 100, -1, 513, 300, 1023, 512, -1, 64};
  int phase_items    [NUM_PHASES] = '{120, 150, 20, 20, 40, 150, 150, 100, 150, 100, 150,
                                      120, 80};

  always #10 clk = ~clk;

  periodic_seed_weight_scorer u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  psws_score_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .cfg_wen       (cfg_wen),
    .cfg_wdata     (cfg_wdata),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .fail_count    (fail_count),
    .expected_left (expected_left)
  );

  // Stall the result side: mostly short stalls, a few long ones
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else if (!ready_steady && $urandom_range(0, 99) < 20) begin
      stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (send_steady || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [63:0] rand_pattern();
    logic [63:0] a, b;
    a = {$urandom, $urandom};
    b = {$urandom, $urandom};
    case ($urandom_range(0, 3))
      0:       return a & b;
      1:       return a | b;
      default: return a;
    endcase
  endfunction

  // Pick a length that mostly leaves whole >= 1, favoring short patterns
  function automatic logic [6:0] pick_len(input int rl);
    int r, limit;
    r = $urandom_range(0, 99);
    if (r < 4) return ($urandom_range(0, 1) == 0) ? 7'd0 : 7'($urandom_range(65, 127));
    if (r < 10) return 7'($urandom_range(1, 64));
    limit = ((rl > 512) ? 512 : rl) / 2;
    if (limit > 64) limit = 64;
    if (limit < 1) limit = 1;
    if ($urandom_range(0, 3) == 0) return 7'($urandom_range(1, limit));
    return 7'($urandom_range(1, (limit < 16) ? limit : 16));
  endfunction

  // Present one item after a random gap and hold it until taken
  task automatic send_item(input logic [63:0] pat, input logic [6:0] n);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {1'b0, n, pat};
    do @(posedge clk); while (!s_tready);
  endtask

  // Drop valid and wait for every due result to come back
  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (expected_left != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_read_len(input logic [9:0] value);
    @(negedge clk);
    cfg_wen   <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_wen   <= 1'b0;
  endtask

  // Bound the run
  initial begin
    #50_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    int rl, ph, i;
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // Directed: reset read length of 100
    send_item({64{1'b1}}, 7'd0);                 // bad length zero
    send_item({64{1'b1}}, 7'd65);                // bad length just above max
    send_item({64{1'b1}}, 7'd127);               // bad length, all bits set
    send_item({64{1'b1}}, 7'd64);                // read too short for 64
    send_item({64{1'b1}}, 7'd50);                // new best
    send_item(64'h1, 7'd1);                      // new best, single cell
    send_item(64'h0, 7'd1);                      // no valid start
    send_item({{54{1'b1}}, 10'h3FF}, 7'd10);     // high bits ignored, below
    send_item({{61{1'b1}}, 3'b001}, 7'd3);       // lone one, end misses
    send_item(64'h0, 7'd33);                     // all zeros
    send_item(64'h3, 7'd2);
    send_item(64'h55, 7'd7);
    drain();

    // Directed: read length above the cap, then the short extremes
    write_read_len(10'h3FF);
    send_item(64'h1, 7'd1);                      // capped read length
    send_item({64{1'b1}}, 7'd64);
    send_item(64'h8000_0000_0000_0001, 7'd64);
    send_item(64'h1, 7'd1);                      // equals best
    drain();
    write_read_len(10'd0);
    send_item(64'h1, 7'd1);
    drain();
    write_read_len(10'd1);
    send_item(64'h1, 7'd1);
    drain();
    write_read_len(10'd2);
    send_item(64'h1, 7'd1);
    send_item(64'hFFFF_FFFF_FFFF_FFFE, 7'd1);
    drain();

    // Random phases over a sweep of read lengths
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      rl = (phase_read_len[ph] < 0) ? $urandom_range(2, 512) : phase_read_len[ph];
      write_read_len(10'(rl));
      send_steady  = ($urandom_range(0, 3) == 0);
      ready_steady = ($urandom_range(0, 3) == 0);
      for (i = 0; i < phase_items[ph]; i++) begin
        send_item(rand_pattern(), pick_len(rl));
        if ($urandom_range(0, 199) == 0) drain();
      end
      drain();
    end

    repeat (20) @(negedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
